// ===== hdl/bipartite_ring_buffer_macros.svh =====
// ----------------------------------------------------------------------------
// bipartite ring buffer assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef BIPARTITE_RING_BUFFER_MACROS_SVH
`define BIPARTITE_RING_BUFFER_MACROS_SVH

`ifndef SYNTHESIS

// check sampled on the rising clock edge, quiet while reset is high
`define BRB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bipartite ring buffer check failed");

// check sampled on every rising clock edge, reset included
`define BRB_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bipartite ring buffer check failed");

`else

`define BRB_ASSERT(label, clk, rst, prop)

`define BRB_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== hdl/bipbuf_pkg.sv =====
// ----------------------------------------------------------------------------
// bipbuf_pkg
// field widths, request kinds and controller/datapath interface types
// ----------------------------------------------------------------------------
package bipbuf_pkg;

   localparam int KIND_W     = 3;
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 13;
   localparam int OFF_W      = 12;
   localparam int COUNT_W    = 13;
   localparam int START_W    = 12;
   localparam int TOTAL_W    = 13;
   localparam int CSR_W      = 13;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 1;

   localparam int USED_SIZE_RESET = 4096;

   localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_COMMIT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd4;

   typedef struct packed {
      logic clear_step;
      logic exec;
      logic peek_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic req_is_peek;
      logic rsp_free;
   } ctrl_status_type;

endpackage

// ===== hdl/bipbuf_ram.sv =====
// ----------------------------------------------------------------------------
// bipbuf_ram
// single port ram, read before write, registered read data
// ----------------------------------------------------------------------------
module bipbuf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/bipbuf_ctrl.sv =====
// ----------------------------------------------------------------------------
// bipbuf_ctrl
// sequencer: store clearing pass, request accept, peek read wait
// ----------------------------------------------------------------------------
`include "bipartite_ring_buffer_macros.svh"

module bipbuf_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  bipbuf_pkg::ctrl_status_type status,
   output bipbuf_pkg::ctrl_cmd_type    cmd
);

   import bipbuf_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PEEK
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      req_tready     = (state_ff == ST_IDLE) && status.rsp_free;
      cmd.exec       = req_tvalid && req_tready;
      cmd.clear_step = (state_ff == ST_CLEAR);
      cmd.peek_load  = (state_ff == ST_PEEK);
      state_in       = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd.exec && status.req_is_peek) begin
               state_in = ST_PEEK;
            end
         end
         ST_PEEK: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `BRB_ASSERT(a_peek_wait, clock, reset, (cmd.exec && status.req_is_peek) |=> state_ff == ST_PEEK)
   `BRB_ASSERT(a_peek_once, clock, reset, (state_ff == ST_PEEK) |=> state_ff == ST_IDLE)
   `BRB_ASSERT(a_clear_holds, clock, reset, (state_ff == ST_CLEAR && !status.clear_last) |=> state_ff == ST_CLEAR)

endmodule

// ===== hdl/bipbuf_datapath.sv =====
// ----------------------------------------------------------------------------
// bipbuf_datapath
// region positions, request evaluation, byte store and response register
// ----------------------------------------------------------------------------
`include "bipartite_ring_buffer_macros.svh"

module bipbuf_datapath #(
   parameter int DEPTH = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [bipbuf_pkg::CSR_W-1:0]         csr_wdata,
   input  logic [bipbuf_pkg::KIND_W-1:0]        req_tuser,
   input  logic [bipbuf_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  bipbuf_pkg::ctrl_cmd_type             cmd,
   output bipbuf_pkg::ctrl_status_type          status,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bipbuf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [bipbuf_pkg::RSP_USER_W-1:0]    rsp_tuser
);

   import bipbuf_pkg::*;

   localparam int PW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = ((PW > LEN_W) ? PW : LEN_W) + 1;
   localparam int USED_RESET = (USED_SIZE_RESET > DEPTH) ? DEPTH : USED_SIZE_RESET;

   // request fields
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] data_byte;
   logic [LEN_W-1:0]  length;
   logic [OFF_W-1:0]  offset;

   // state
   logic [PW-1:0]      used_ff;
   logic [PW-1:0]      rp_ff;
   logic [PW-1:0]      ae_ff;
   logic [PW-1:0]      be_ff;
   logic [PW-1:0]      rp_in;
   logic [PW-1:0]      ae_in;
   logic [PW-1:0]      be_in;
   logic [AW-1:0]      clr_cnt_ff;
   logic               pk_ok_ff;
   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [BYTE_W-1:0]  read_byte_ff;
   logic               byte_valid_ff;
   logic [START_W-1:0] block_start_ff;

   // evaluation
   logic [CW-1:0] u, rp, ae, be, len, ofs, cfg_v, used_clamp;
   logic [CW-1:0] rp_n, ae_n, be_n, cnt, bs, n_v, rest_v, wr_addr, pk_idx, total;
   logic          a_full, full, empty, wr_en, pk_ok;

   // store port
   logic              ram_we;
   logic [AW-1:0]     ram_addr;
   logic [BYTE_W-1:0] ram_wdata;
   logic [BYTE_W-1:0] ram_rdata;

   assign kind      = req_tuser;
   assign data_byte = req_tdata[BYTE_W-1:0];
   assign length    = req_tdata[BYTE_W+LEN_W-1:BYTE_W];
   assign offset    = req_tdata[BYTE_W+LEN_W+OFF_W-1:BYTE_W+LEN_W];

   always_comb begin
      cfg_v = CW'(csr_wdata);
      if (cfg_v == '0) begin
         used_clamp = CW'(1);
      end else if (cfg_v > CW'(DEPTH)) begin
         used_clamp = CW'(DEPTH);
      end else begin
         used_clamp = cfg_v;
      end
   end

   always_comb begin
      u      = CW'(used_ff);
      rp     = CW'(rp_ff);
      ae     = CW'(ae_ff);
      be     = CW'(be_ff);
      len    = CW'(length);
      ofs    = CW'(offset);
      a_full = (ae >= u);
      full   = a_full && (be >= rp);
      empty  = (rp == ae) && (be == '0);
      rp_n    = rp;
      ae_n    = ae;
      be_n    = be;
      cnt     = '0;
      bs      = '0;
      n_v     = '0;
      rest_v  = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      pk_idx  = rp + ofs;
      pk_ok   = 1'b0;
      unique case (kind)
         KIND_WRITE: begin
            if (!full) begin
               wr_en = 1'b1;
               cnt   = CW'(1);
               if (a_full) begin
                  wr_addr = be;
                  be_n    = be + CW'(1);
               end else begin
                  wr_addr = ae;
                  ae_n    = ae + CW'(1);
               end
            end
         end
         KIND_COMMIT: begin
            if (len != '0 && !full) begin
               if (a_full) begin
                  n_v = rp - be;
                  if (len < n_v) begin
                     n_v = len;
                  end
                  be_n = be + n_v;
                  cnt  = n_v;
               end else begin
                  n_v = u - ae;
                  if (len <= n_v) begin
                     ae_n = ae + len;
                     cnt  = len;
                  end else begin
                     ae_n = u;
                     cnt  = n_v;
                     if (rp != '0) begin
                        rest_v = len - n_v;
                        if (rest_v > rp) begin
                           rest_v = rp;
                        end
                        be_n = be + rest_v;
                        cnt  = n_v + rest_v;
                     end
                  end
               end
            end
         end
         KIND_REMOVE: begin
            if (len != '0 && !empty) begin
               if (!a_full) begin
                  n_v = ae - rp;
                  if (len < n_v) begin
                     n_v = len;
                  end
                  rp_n = rp + n_v;
                  cnt  = n_v;
               end else begin
                  n_v = u - rp;
                  if (len < n_v) begin
                     rp_n = rp + len;
                     cnt  = len;
                  end else begin
                     rest_v = len - n_v;
                     if (rest_v > be) begin
                        rest_v = be;
                     end
                     cnt  = n_v + rest_v;
                     rp_n = rest_v;
                     ae_n = be;
                     be_n = '0;
                  end
               end
            end
         end
         KIND_PEEK: begin
            if (!empty) begin
               if (!a_full) begin
                  pk_ok = (pk_idx < ae);
               end else if (pk_idx >= u) begin
                  pk_idx = pk_idx - u;
                  pk_ok  = (pk_idx < be);
               end else begin
                  pk_ok = 1'b1;
               end
               pk_ok = pk_ok && (pk_idx < CW'(DEPTH));
            end
         end
         KIND_QUERY: begin
            if (a_full) begin
               if (be < rp) begin
                  bs  = be;
                  cnt = rp - be;
               end
            end else begin
               bs  = ae;
               cnt = u - ae;
            end
         end
         default: begin
         end
      endcase
      rp_in = PW'(rp_n);
      ae_in = PW'(ae_n);
      be_in = PW'(be_n);
   end

   always_comb begin
      ram_we    = cmd.clear_step || (cmd.exec && wr_en);
      ram_wdata = cmd.clear_step ? '0 : data_byte;
      if (cmd.clear_step) begin
         ram_addr = clr_cnt_ff;
      end else if (wr_en) begin
         ram_addr = AW'(wr_addr);
      end else begin
         ram_addr = AW'(pk_idx);
      end
   end

   bipbuf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= PW'(USED_RESET);
         rp_ff      <= '0;
         ae_ff      <= '0;
         be_ff      <= '0;
         clr_cnt_ff <= '0;
      end else begin
         if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + AW'(1);
         end
         if (csr_we) begin
            used_ff <= PW'(used_clamp);
            rp_ff   <= '0;
            ae_ff   <= '0;
            be_ff   <= '0;
         end else if (cmd.exec) begin
            rp_ff <= rp_in;
            ae_ff <= ae_in;
            be_ff <= be_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec) begin
         rsp_valid_ff <= (kind != KIND_PEEK);
      end else if (cmd.peek_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         pk_ok_ff       <= pk_ok;
         count_ff       <= COUNT_W'(cnt);
         block_start_ff <= START_W'(bs);
         read_byte_ff   <= '0;
         byte_valid_ff  <= 1'b0;
      end else if (cmd.peek_load) begin
         count_ff       <= '0;
         block_start_ff <= '0;
         read_byte_ff   <= pk_ok_ff ? ram_rdata : '0;
         byte_valid_ff  <= pk_ok_ff;
      end
   end

   // positions hold the post-step values while the response waits, unless used_size is written
   assign total = (CW'(ae_ff) - CW'(rp_ff)) + CW'(be_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {
      {(RSP_DATA_W - COUNT_W - BYTE_W - START_W - TOTAL_W){1'b0}},
      TOTAL_W'(total),
      block_start_ff,
      read_byte_ff,
      count_ff
   };
   assign rsp_tuser  = byte_valid_ff;

   assign status.clear_last  = (clr_cnt_ff == AW'(DEPTH - 1));
   assign status.req_is_peek = (kind == KIND_PEEK);
   assign status.rsp_free    = !rsp_valid_ff || rsp_tready;

   `BRB_ASSERT(a_region_order, clock, reset, (be_ff <= rp_ff) && (rp_ff <= ae_ff))
   `BRB_ASSERT(a_region_bound, clock, reset, (ae_ff <= used_ff) && (used_ff != '0))
   `BRB_ASSERT(a_peek_result, clock, reset, cmd.peek_load |=> rsp_valid_ff)

endmodule

// ===== hdl/bipartite_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// bipartite_ring_buffer
// two-region byte ring buffer with write, commit, remove, peek and
// free-block query requests
// ----------------------------------------------------------------------------
// After reset the byte store is cleared to zero in a pass over all DEPTH
// addresses (4096 by default), one byte a cycle, during which req_tready stays low;
// csr writes are taken during that pass as at any other time. Write, commit,
// remove and query requests then update the three region positions and load the
// response into the output register when they are accepted. A peek addresses the
// single-port byte store when accepted; since its read data is registered, the byte
// is loaded into the output register from the PEEK state, in which no request is
// taken. A new request is taken while the previous response is being taken in the
// same cycle. Writing used_size empties the buffer but keeps the stored bytes.
module bipartite_ring_buffer #(
   parameter int DEPTH = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // used_size
   input  logic                                 csr_we,
   input  logic [bipbuf_pkg::CSR_W-1:0]         csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // data_byte[7:0], length[20:8], offset[32:21], zero pad
   input  logic [bipbuf_pkg::REQ_DATA_W-1:0]    req_tdata,
   // kind[2:0]
   input  logic [bipbuf_pkg::KIND_W-1:0]        req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // count[12:0], read_byte[20:13], block_start[32:21], stored_total[45:33], zero pad
   output logic [bipbuf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // byte_valid[0]
   output logic [bipbuf_pkg::RSP_USER_W-1:0]    rsp_tuser
);

   import bipbuf_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   bipbuf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bipbuf_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== tb/sv/tb_bipartite_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// bipartite ring buffer testbench
// drives write, commit, remove, peek and query requests through the stream
// ports under several used_size settings, predicts every response with a
// model of the two regions and the byte store, and compares each field
// ----------------------------------------------------------------------------
package bipbuf_tb_pkg;

   import bipbuf_pkg::*;

   localparam int STORE_DEPTH = 4096;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data_byte;
      logic [LEN_W-1:0]  length;
      logic [OFF_W-1:0]  offset;
   } bipbuf_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [BYTE_W-1:0]  read_byte;
      logic               byte_valid;
      logic [START_W-1:0] block_start;
      logic [TOTAL_W-1:0] stored_total;
   } bipbuf_rsp_type;

   class ring_state_checker;
      logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
      logic [LEN_W-1:0]  used_size;
      logic [LEN_W-1:0]  rd_pos;
      logic [LEN_W-1:0]  a_end;
      logic [LEN_W-1:0]  b_end;
      bipbuf_rsp_type    pending_rsp_q [$];
      int unsigned       mismatches;

      function new();
         foreach (store_mem[i]) store_mem[i] = '0;
         used_size  = LEN_W'(USED_SIZE_RESET);
         rd_pos     = '0;
         a_end      = '0;
         b_end      = '0;
         mismatches = 0;
      endfunction

      function void set_used_size(logic [CSR_W-1:0] v);
         if (v == 0) begin
            used_size = LEN_W'(1);
         end else if (v > STORE_DEPTH) begin
            used_size = LEN_W'(STORE_DEPTH);
         end else begin
            used_size = v;
         end
         rd_pos = '0;
         a_end  = '0;
         b_end  = '0;
      endfunction

      function bit ring_drained();
         return rd_pos == a_end && b_end == 0;
      endfunction

      function bit is_full();
         return a_end >= used_size && b_end >= rd_pos;
      endfunction

      function logic [TOTAL_W-1:0] stored();
         return (a_end - rd_pos) + b_end;
      endfunction

      function logic [COUNT_W-1:0] commit_bytes(logic [LEN_W-1:0] len);
         logic [LEN_W-1:0] n;
         logic [LEN_W-1:0] rest;
         if (len == 0 || is_full()) return '0;
         if (a_end >= used_size) begin
            n = rd_pos - b_end;
            if (len < n) n = len;
            b_end += n;
            return n;
         end
         n = used_size - a_end;
         if (len <= n) begin
            a_end += len;
            return len;
         end
         a_end = used_size;
         if (rd_pos > 0) begin
            rest = len - n;
            if (rest > rd_pos) rest = rd_pos;
            b_end += rest;
            n += rest;
         end
         return n;
      endfunction

      function logic [COUNT_W-1:0] remove_bytes(logic [LEN_W-1:0] len);
         logic [LEN_W-1:0] n;
         logic [LEN_W-1:0] rest;
         if (len == 0 || ring_drained()) return '0;
         if (a_end < used_size) begin
            n = a_end - rd_pos;
            if (len < n) n = len;
            rd_pos += n;
            return n;
         end
         n = used_size - rd_pos;
         if (len < n) begin
            rd_pos += len;
            return len;
         end
         // region b becomes region a
         rest = len - n;
         if (rest > b_end) rest = b_end;
         n += rest;
         rd_pos = rest;
         a_end  = b_end;
         b_end  = '0;
         return n;
      endfunction

      function bipbuf_rsp_type predict(bipbuf_req_type r);
         bipbuf_rsp_type   e;
         logic [LEN_W-1:0] idx;
         bit               ok;
         e = '0;
         case (r.kind)
            KIND_WRITE: begin
               if (!is_full()) begin
                  if (a_end >= used_size) begin
                     store_mem[b_end[STORE_AW-1:0]] = r.data_byte;
                     b_end++;
                  end else begin
                     store_mem[a_end[STORE_AW-1:0]] = r.data_byte;
                     a_end++;
                  end
                  e.count = COUNT_W'(1);
               end
            end
            KIND_COMMIT: e.count = commit_bytes(r.length);
            KIND_REMOVE: e.count = remove_bytes(r.length);
            KIND_PEEK: begin
               if (!ring_drained()) begin
                  idx = rd_pos + LEN_W'(r.offset);
                  if (a_end < used_size) begin
                     ok = idx < a_end;
                  end else if (idx >= used_size) begin
                     idx -= used_size;
                     ok = idx < b_end;
                  end else begin
                     ok = 1'b1;
                  end
                  if (ok && idx < STORE_DEPTH) begin
                     e.byte_valid = 1'b1;
                     e.read_byte  = store_mem[idx[STORE_AW-1:0]];
                  end
               end
            end
            KIND_QUERY: begin
               if (a_end >= used_size) begin
                  if (b_end < rd_pos) begin
                     e.block_start = b_end[START_W-1:0];
                     e.count       = rd_pos - b_end;
                  end
               end else begin
                  e.block_start = a_end[START_W-1:0];
                  e.count       = used_size - a_end;
               end
            end
            default: ;
         endcase
         e.stored_total = stored();
         return e;
      endfunction

      function void note_request(bipbuf_req_type r);
         pending_rsp_q.push_back(predict(r));
      endfunction

      task report(string msg);
         mismatches++;
         $display("[%0t] mismatch: %s", $time, msg);
      endtask

      task check_response(bipbuf_rsp_type got);
         bipbuf_rsp_type want;
         if (pending_rsp_q.size() == 0) begin
            report("response with no request waiting");
            return;
         end
         want = pending_rsp_q.pop_front();
         if (got.count != want.count)
            report($sformatf("count got %0d want %0d", got.count, want.count));
         if (got.read_byte != want.read_byte)
            report($sformatf("read_byte got %0h want %0h", got.read_byte, want.read_byte));
         if (got.byte_valid != want.byte_valid)
            report($sformatf("byte_valid got %0b want %0b", got.byte_valid, want.byte_valid));
         if (got.block_start != want.block_start)
            report($sformatf("block_start got %0d want %0d", got.block_start,
                             want.block_start));
         if (got.stored_total != want.stored_total)
            report($sformatf("stored_total got %0d want %0d", got.stored_total,
                             want.stored_total));
      endtask
   endclass

endpackage

module tb_bipartite_ring_buffer;

   import bipbuf_pkg::*;
   import bipbuf_tb_pkg::*;

   localparam int IDLE_LIMIT     = 20000;
   localparam int RX_HOLD_CYCLES = 60;
   localparam int PHASE_COUNT    = 10;
   localparam int PHASE_ITEMS    = 85;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_W-1:0]      csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [KIND_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   ring_state_checker ring;
   bit                tx_quiet;
   bit                rx_quiet;
   int unsigned       hold_epoch;
   int unsigned       idle_cycles;

   bipartite_ring_buffer #(
      .DEPTH (STORE_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task send_request(bipbuf_req_type r);
      int unsigned gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {7'd0, r.offset, r.length, r.data_byte};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ring.note_request(r);
   endtask

   task send_fields(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data_byte,
                    logic [LEN_W-1:0] length, logic [OFF_W-1:0] offset);
      bipbuf_req_type r;
      r.kind      = kind;
      r.data_byte = data_byte;
      r.length    = length;
      r.offset    = offset;
      send_request(r);
   endtask

   task wait_drained();
      req_tvalid <= 1'b0;
      while (ring.pending_rsp_q.size() != 0) @(posedge clock);
   endtask

   task write_used_size(logic [CSR_W-1:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      ring.set_used_size(v);
      csr_we    <= 1'b0;
   endtask

   function bipbuf_req_type random_request();
      bipbuf_req_type r;
      int unsigned    pick;
      int unsigned    lim;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         r.kind = KIND_WRITE;
      end else if (pick < 52) begin
         r.kind = KIND_COMMIT;
      end else if (pick < 72) begin
         r.kind = KIND_REMOVE;
      end else if (pick < 90) begin
         r.kind = KIND_PEEK;
      end else if (pick < 97) begin
         r.kind = KIND_QUERY;
      end else begin
         r.kind = KIND_W'($urandom_range(KIND_QUERY + 1, 2**KIND_W - 1));
      end
      r.data_byte = BYTE_W'($urandom_range(0, 2**BYTE_W - 1));
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         r.length = LEN_W'($urandom_range(0, 8));
      end else if (pick < 8) begin
         r.length = LEN_W'($urandom_range(0, ring.used_size + 2));
      end else begin
         r.length = LEN_W'($urandom_range(0, 2**LEN_W - 1));
      end
      lim = ring.stored() + 2;
      if (lim > 2**OFF_W - 1) lim = 2**OFF_W - 1;
      if ($urandom_range(0, 9) < 6) begin
         r.offset = OFF_W'($urandom_range(0, lim));
      end else begin
         r.offset = OFF_W'($urandom_range(0, 2**OFF_W - 1));
      end
      return r;
   endfunction

   initial begin : rx_proc
      int unsigned    wait_cycles;
      int unsigned    seen_epoch;
      bipbuf_rsp_type got;
      seen_epoch = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         wait_cycles = rx_quiet ? 0 : $urandom_range(0, 3);
         // long hold so the output register fills and the input stalls
         if (hold_epoch != seen_epoch) begin
            seen_epoch = hold_epoch;
            wait_cycles += RX_HOLD_CYCLES;
         end
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got.count        = rsp_tdata[12:0];
         got.read_byte    = rsp_tdata[20:13];
         got.block_start  = rsp_tdata[32:21];
         got.stored_total = rsp_tdata[45:33];
         got.byte_valid   = rsp_tuser[0];
         ring.check_response(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stim_proc
      logic [CSR_W-1:0] sizes [PHASE_COUNT];
      int unsigned      phase;
      int unsigned      n;
      reset       <= 1'b1;
      csr_we      <= 1'b0;
      csr_wdata   <= '0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      tx_quiet    = 1'b0;
      rx_quiet    = 1'b0;
      hold_epoch  = 0;
      ring = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // small buffer so full, wrap and region swap show up quickly
      write_used_size(13'd4);
      send_fields(KIND_PEEK,   8'h00, 13'd0,    12'd0);
      send_fields(KIND_REMOVE, 8'h00, 13'd5,    12'd0);
      send_fields(KIND_QUERY,  8'h00, 13'd0,    12'd0);
      send_fields(KIND_WRITE,  8'h00, 13'd0,    12'd0);
      send_fields(KIND_WRITE,  8'hff, 13'd0,    12'd0);
      send_fields(KIND_WRITE,  8'ha5, 13'd0,    12'd0);
      send_fields(KIND_PEEK,   8'h00, 13'd0,    12'd0);
      send_fields(KIND_PEEK,   8'h00, 13'd0,    12'd2);
      send_fields(KIND_PEEK,   8'h00, 13'd0,    12'd3);
      send_fields(KIND_PEEK,   8'h00, 13'd0,    12'hfff);
      send_fields(KIND_COMMIT, 8'h00, 13'd0,    12'd0);
      send_fields(KIND_COMMIT, 8'h00, 13'h1fff, 12'd0);
      send_fields(KIND_WRITE,  8'h3c, 13'd0,    12'd0);
      send_fields(KIND_QUERY,  8'h00, 13'd0,    12'd0);
      send_fields(KIND_REMOVE, 8'h00, 13'd1,    12'd0);
      send_fields(KIND_QUERY,  8'h00, 13'd0,    12'd0);
      send_fields(KIND_WRITE,  8'h5a, 13'd0,    12'd0);
      send_fields(KIND_PEEK,   8'h00, 13'd0,    12'd3);
      send_fields(KIND_REMOVE, 8'h00, 13'd0,    12'd0);
      send_fields(KIND_REMOVE, 8'h00, 13'd3,    12'd0);
      send_fields(KIND_COMMIT, 8'h00, 13'd4096, 12'd0);
      send_fields(KIND_REMOVE, 8'h00, 13'h1fff, 12'd0);
      send_fields(3'd5,        8'h11, 13'd1,    12'd1);
      send_fields(3'd6,        8'h22, 13'd2,    12'd0);
      send_fields(3'd7,        8'h33, 13'd4096, 12'd0);
      send_fields(KIND_REMOVE, 8'h00, 13'd4096, 12'd0);
      wait_drained();

      sizes[0] = 13'd0;
      sizes[1] = 13'd1;
      sizes[2] = 13'd2;
      sizes[3] = 13'd4096;
      sizes[4] = 13'h1fff;
      sizes[5] = 13'd33;
      sizes[6] = CSR_W'($urandom_range(5, 64));
      sizes[7] = CSR_W'($urandom_range(1, 2**CSR_W - 1));
      sizes[8] = 13'd3;
      sizes[9] = CSR_W'($urandom_range(65, 4095));
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         write_used_size(sizes[phase]);
         tx_quiet = ($urandom_range(0, 3) == 0);
         rx_quiet = ($urandom_range(0, 3) == 0);
         if (phase == 1 || phase == 5) hold_epoch++;
         for (n = 0; n < PHASE_ITEMS; n++) send_request(random_request());
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (ring.mismatches == 0 && ring.pending_rsp_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
